// File: rtl/fras_pkg.sv
// Shared types and constants for the four-register ALU stack executor.
`default_nettype none

package fras_pkg;

  localparam int unsigned DefStackDepth = 16;
  localparam int unsigned DataW         = 32;
  localparam int unsigned OpW           = 4;
  localparam int unsigned RegIdxW       = 2;
  localparam int unsigned DepthW        = 5;

  typedef enum logic [OpW-1:0] {
    OP_MOV  = 4'd0,
    OP_ADD  = 4'd1,
    OP_SUB  = 4'd2,
    OP_MUL  = 4'd3,
    OP_DIV  = 4'd4,
    OP_XOR  = 4'd5,
    OP_AND  = 4'd6,
    OP_OR   = 4'd7,
    OP_SHL  = 4'd8,
    OP_SHR  = 4'd9,
    OP_PUSH = 4'd10,
    OP_POP  = 4'd11
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_DIV0  = 2'd1,
    STAT_OVER  = 2'd2,
    STAT_UNDER = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CLS_ALU,
    CLS_MUL,
    CLS_DIV,
    CLS_PUSH,
    CLS_POP,
    CLS_NOP
  } cls_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_EXEC,
    BK_DIV,
    BK_POPRD,
    BK_COMMIT
  } back_state_e;

  typedef struct packed {
    cls_e               cls;
    logic [OpW-1:0]     op;
    logic [RegIdxW-1:0] dst;
    logic               src_is_reg;
    logic [RegIdxW-1:0] src_reg;
    logic [DataW-1:0]   imm;
  } instr_t;

  typedef struct packed {
    logic   valid;
    instr_t item;
  } deq_t;

endpackage

`default_nettype wire

// File: rtl/four_register_alu_stack_executor_core.sv
// Top level of the four-register ALU stack executor.
//
//   Channel   Handshake    Word contents
//   input     push, full   op, dest_reg, src_is_reg, src_reg, immediate
//   result    empty, pop   status, reg_a .. reg_d, depth
//
// An accepted word waits in a two-entry queue and then passes the executor states dequeue,
// execute and commit; a pop from a nonempty stack adds a state for its registered stack
// read, and a divide by a nonzero value waits in a divide state for the 32-step radix-2
// divider and its done strobe. Reset clears the registers and empties the stack at once;
// stack entries are never read before they are written.
// While a result is not popped the executor holds in commit, the queue fills and full rises.
`default_nettype none

module four_register_alu_stack_executor_core #(
  parameter int unsigned StackDepth = fras_pkg::DefStackDepth
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               push,
  output      logic                               full,
  input  wire logic [fras_pkg::OpW-1:0]           op_i,
  input  wire logic [fras_pkg::RegIdxW-1:0]       dest_reg_i,
  input  wire logic                               src_is_reg_i,
  input  wire logic [fras_pkg::RegIdxW-1:0]       src_reg_i,
  input  wire logic signed [fras_pkg::DataW-1:0]  immediate_i,
  output      logic                               empty,
  input  wire logic                               pop,
  output      logic [1:0]                         status_o,
  output      logic signed [fras_pkg::DataW-1:0]  reg_a_o,
  output      logic signed [fras_pkg::DataW-1:0]  reg_b_o,
  output      logic signed [fras_pkg::DataW-1:0]  reg_c_o,
  output      logic signed [fras_pkg::DataW-1:0]  reg_d_o,
  output      logic [fras_pkg::DepthW-1:0]        depth_o
);

  fras_pkg::deq_t deq;
  logic           deq_ack;

  fras_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .op_i         (op_i),
    .dest_reg_i   (dest_reg_i),
    .src_is_reg_i (src_is_reg_i),
    .src_reg_i    (src_reg_i),
    .immediate_i  (immediate_i),
    .deq_o        (deq),
    .deq_ack_i    (deq_ack)
  );

  fras_back #(
    .StackDepth (StackDepth)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .deq_i     (deq),
    .deq_ack_o (deq_ack),
    .pop_i     (pop),
    .empty_o   (empty),
    .status_o  (status_o),
    .reg_a_o   (reg_a_o),
    .reg_b_o   (reg_b_o),
    .reg_c_o   (reg_c_o),
    .reg_d_o   (reg_d_o),
    .depth_o   (depth_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == fras_pkg::STAT_UNDER) |-> (depth_o == '0))
    else $error("Underflow reported with a nonempty stack.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == fras_pkg::STAT_OVER) |-> (depth_o == fras_pkg::DepthW'(StackDepth)))
    else $error("Overflow reported with a stack that is not full.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("Input queue filled without an accepted word.");

endmodule

`default_nettype wire

// File: rtl/fras_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fras_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                          wdata_i,
  input  wire logic                                      re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output      logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/fras_front.sv
// Front end: accepts instruction words, classifies them and queues them for execution.
`default_nettype none

module fras_front (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               push_i,
  output      logic                               full_o,
  input  wire logic [fras_pkg::OpW-1:0]           op_i,
  input  wire logic [fras_pkg::RegIdxW-1:0]       dest_reg_i,
  input  wire logic                               src_is_reg_i,
  input  wire logic [fras_pkg::RegIdxW-1:0]       src_reg_i,
  input  wire logic signed [fras_pkg::DataW-1:0]  immediate_i,
  output      fras_pkg::deq_t                     deq_o,
  input  wire logic                               deq_ack_i
);

  function automatic fras_pkg::cls_e classify(logic [fras_pkg::OpW-1:0] op);
    fras_pkg::cls_e cls;
    unique case (fras_pkg::op_e'(op))
      fras_pkg::OP_MOV, fras_pkg::OP_ADD, fras_pkg::OP_SUB, fras_pkg::OP_XOR,
      fras_pkg::OP_AND, fras_pkg::OP_OR, fras_pkg::OP_SHL,
      fras_pkg::OP_SHR:  cls = fras_pkg::CLS_ALU;
      fras_pkg::OP_MUL:  cls = fras_pkg::CLS_MUL;
      fras_pkg::OP_DIV:  cls = fras_pkg::CLS_DIV;
      fras_pkg::OP_PUSH: cls = fras_pkg::CLS_PUSH;
      fras_pkg::OP_POP:  cls = fras_pkg::CLS_POP;
      default:           cls = fras_pkg::CLS_NOP;
    endcase
    return cls;
  endfunction

  fras_pkg::instr_t ent_q [2];
  fras_pkg::instr_t new_ent;
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             enq, deq;

  assign full_o = (cnt_q == 2'd2);
  assign enq    = push_i && !full_o;
  assign deq    = deq_ack_i && deq_o.valid;

  assign deq_o.valid = (cnt_q != 2'd0);
  assign deq_o.item  = ent_q[rd_ptr_q];

  always_comb begin
    new_ent.cls        = classify(op_i);
    new_ent.op         = op_i;
    new_ent.dst        = dest_reg_i;
    new_ent.src_is_reg = src_is_reg_i;
    new_ent.src_reg    = src_reg_i;
    new_ent.imm        = immediate_i;
  end

  always_comb begin
    wr_ptr_d = enq ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = deq ? !rd_ptr_q : rd_ptr_q;
    priority if (enq && !deq) begin
      cnt_d = cnt_q + 2'd1;
    end else if (deq && !enq) begin
      cnt_d = cnt_q - 2'd1;
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      ent_q[wr_ptr_q] <= new_ent;
    end
  end

endmodule

`default_nettype wire

// File: rtl/fras_div.sv
// Iterative signed divider producing one quotient bit per cycle.
`default_nettype none

module fras_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [fras_pkg::DataW-1:0]  dividend_i,
  input  wire logic [fras_pkg::DataW-1:0]  divisor_i,
  output      logic                        done_o,
  output      logic [fras_pkg::DataW-1:0]  quotient_o
);

  localparam int unsigned W    = fras_pkg::DataW;
  localparam int unsigned CntW = $clog2(W);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic            neg_q;
  logic [W-1:0]    rem_q;
  logic [W-1:0]    quo_q;
  logic [W-1:0]    md_q;
  logic [W:0]      trial;

  assign trial = {rem_q, quo_q[W-1]} - {1'b0, md_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[W-1] ^ divisor_i[W-1];
      quo_q <= dividend_i[W-1] ? (W'(0) - dividend_i) : dividend_i;
      md_q  <= divisor_i[W-1] ? (W'(0) - divisor_i) : divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_q <= trial[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[W-2:0], quo_q[W-1]};
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (W'(0) - quo_q) : quo_q;

endmodule

`default_nettype wire

// File: rtl/fras_back.sv
// Back end: executes queued instructions on the register file and the value stack.
`default_nettype none

module fras_back #(
  parameter int unsigned StackDepth = fras_pkg::DefStackDepth
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire fras_pkg::deq_t                     deq_i,
  output      logic                               deq_ack_o,
  input  wire logic                               pop_i,
  output      logic                               empty_o,
  output      logic [1:0]                         status_o,
  output      logic signed [fras_pkg::DataW-1:0]  reg_a_o,
  output      logic signed [fras_pkg::DataW-1:0]  reg_b_o,
  output      logic signed [fras_pkg::DataW-1:0]  reg_c_o,
  output      logic signed [fras_pkg::DataW-1:0]  reg_d_o,
  output      logic [fras_pkg::DepthW-1:0]        depth_o
);

  localparam int unsigned W     = fras_pkg::DataW;
  localparam int unsigned CntW  = $clog2(StackDepth + 1);
  localparam int unsigned AddrW = (StackDepth > 1) ? $clog2(StackDepth) : 1;

  function automatic logic [W-1:0] pick(logic [fras_pkg::RegIdxW-1:0] idx,
                                        logic [W-1:0] a, logic [W-1:0] b,
                                        logic [W-1:0] c, logic [W-1:0] d);
    logic [W-1:0] v;
    unique case (idx)
      2'd0:    v = a;
      2'd1:    v = b;
      2'd2:    v = c;
      default: v = d;
    endcase
    return v;
  endfunction

  fras_pkg::back_state_e state_q, state_d;

  logic [W-1:0]                 gpr_a_q, gpr_b_q, gpr_c_q, gpr_d_q;
  logic [W-1:0]                 nxt_a, nxt_b, nxt_c, nxt_d;
  logic [CntW-1:0]              cnt_q, cnt_nxt, cnt_dec;
  fras_pkg::cls_e               cls_q;
  logic [fras_pkg::OpW-1:0]     op_q;
  logic [fras_pkg::RegIdxW-1:0] dst_q;
  logic [W-1:0]                 src_q, cur_q, res_q;
  fras_pkg::status_e            stat_q;
  logic                         wr_q;

  logic                         out_valid_q;
  logic [1:0]                   out_stat_q;
  logic [W-1:0]                 out_a_q, out_b_q, out_c_q, out_d_q;
  logic [fras_pkg::DepthW-1:0]  out_depth_q;

  logic         out_free, commit;
  logic         div_start, div_done;
  logic [W-1:0] div_quo;
  logic         ram_we, ram_re;
  logic [W-1:0] ram_rdata;
  logic         stack_full, stack_empty;

  assign out_free    = !out_valid_q || pop_i;
  assign cnt_dec     = cnt_q - CntW'(1);
  assign stack_full  = (cnt_q >= CntW'(StackDepth));
  assign stack_empty = (cnt_q == '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fras_pkg::BK_IDLE: begin
        if (deq_i.valid) begin
          state_d = fras_pkg::BK_EXEC;
        end
      end
      fras_pkg::BK_EXEC: begin
        priority if (cls_q == fras_pkg::CLS_DIV && src_q != '0) begin
          state_d = fras_pkg::BK_DIV;
        end else if (cls_q == fras_pkg::CLS_POP && !stack_empty) begin
          state_d = fras_pkg::BK_POPRD;
        end else begin
          state_d = fras_pkg::BK_COMMIT;
        end
      end
      fras_pkg::BK_DIV: begin
        if (div_done) begin
          state_d = fras_pkg::BK_COMMIT;
        end
      end
      fras_pkg::BK_POPRD: begin
        state_d = fras_pkg::BK_COMMIT;
      end
      fras_pkg::BK_COMMIT: begin
        if (out_free) begin
          state_d = fras_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = fras_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    deq_ack_o = (state_q == fras_pkg::BK_IDLE) && deq_i.valid;
    div_start = (state_q == fras_pkg::BK_EXEC) && (cls_q == fras_pkg::CLS_DIV) && (src_q != '0);
    ram_re    = (state_q == fras_pkg::BK_EXEC) && (cls_q == fras_pkg::CLS_POP) && !stack_empty;
    commit    = (state_q == fras_pkg::BK_COMMIT) && out_free;
    ram_we    = commit && (cls_q == fras_pkg::CLS_PUSH) && (stat_q == fras_pkg::STAT_OK);
  end

  always_comb begin
    nxt_a = (wr_q && dst_q == 2'd0) ? res_q : gpr_a_q;
    nxt_b = (wr_q && dst_q == 2'd1) ? res_q : gpr_b_q;
    nxt_c = (wr_q && dst_q == 2'd2) ? res_q : gpr_c_q;
    nxt_d = (wr_q && dst_q == 2'd3) ? res_q : gpr_d_q;
    cnt_nxt = cnt_q;
    if (stat_q == fras_pkg::STAT_OK && cls_q == fras_pkg::CLS_PUSH) begin
      cnt_nxt = cnt_q + CntW'(1);
    end else if (stat_q == fras_pkg::STAT_OK && cls_q == fras_pkg::CLS_POP) begin
      cnt_nxt = cnt_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fras_pkg::BK_IDLE;
      gpr_a_q     <= '0;
      gpr_b_q     <= '0;
      gpr_c_q     <= '0;
      gpr_d_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        gpr_a_q     <= nxt_a;
        gpr_b_q     <= nxt_b;
        gpr_c_q     <= nxt_c;
        gpr_d_q     <= nxt_d;
        cnt_q       <= cnt_nxt;
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      fras_pkg::BK_IDLE: begin
        if (deq_i.valid) begin
          cls_q <= deq_i.item.cls;
          op_q  <= deq_i.item.op;
          dst_q <= deq_i.item.dst;
          src_q <= deq_i.item.src_is_reg ?
                   pick(deq_i.item.src_reg, gpr_a_q, gpr_b_q, gpr_c_q, gpr_d_q) :
                   deq_i.item.imm;
          cur_q <= pick(deq_i.item.dst, gpr_a_q, gpr_b_q, gpr_c_q, gpr_d_q);
        end
      end
      fras_pkg::BK_EXEC: begin
        stat_q <= fras_pkg::STAT_OK;
        wr_q   <= 1'b0;
        unique case (cls_q)
          fras_pkg::CLS_ALU: begin
            wr_q <= 1'b1;
            unique case (fras_pkg::op_e'(op_q))
              fras_pkg::OP_MOV: res_q <= src_q;
              fras_pkg::OP_ADD: res_q <= cur_q + src_q;
              fras_pkg::OP_SUB: res_q <= cur_q - src_q;
              fras_pkg::OP_XOR: res_q <= cur_q ^ src_q;
              fras_pkg::OP_AND: res_q <= cur_q & src_q;
              fras_pkg::OP_OR:  res_q <= cur_q | src_q;
              fras_pkg::OP_SHL: res_q <= cur_q << src_q[4:0];
              fras_pkg::OP_SHR: res_q <= W'($signed(cur_q) >>> src_q[4:0]);
              default:          res_q <= cur_q;
            endcase
          end
          fras_pkg::CLS_MUL: begin
            wr_q  <= 1'b1;
            res_q <= cur_q * src_q;
          end
          fras_pkg::CLS_DIV: begin
            if (src_q == '0) begin
              stat_q <= fras_pkg::STAT_DIV0;
            end else begin
              wr_q <= 1'b1;
            end
          end
          fras_pkg::CLS_PUSH: begin
            if (stack_full) begin
              stat_q <= fras_pkg::STAT_OVER;
            end
          end
          fras_pkg::CLS_POP: begin
            if (stack_empty) begin
              stat_q <= fras_pkg::STAT_UNDER;
            end else begin
              wr_q <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      fras_pkg::BK_DIV: begin
        if (div_done) begin
          res_q <= div_quo;
        end
      end
      fras_pkg::BK_POPRD: begin
        res_q <= ram_rdata;
      end
      default: begin
      end
    endcase
    if (commit) begin
      out_stat_q  <= stat_q;
      out_a_q     <= nxt_a;
      out_b_q     <= nxt_b;
      out_c_q     <= nxt_c;
      out_d_q     <= nxt_d;
      out_depth_q <= fras_pkg::DepthW'(cnt_nxt);
    end
  end

  fras_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cur_q),
    .divisor_i  (src_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  fras_ram #(
    .Width (W),
    .Depth (StackDepth)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AddrW-1:0]),
    .wdata_i (src_q),
    .re_i    (ram_re),
    .raddr_i (cnt_dec[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign empty_o  = !out_valid_q;
  assign status_o = out_stat_q;
  assign reg_a_o  = out_a_q;
  assign reg_b_o  = out_b_q;
  assign reg_c_o  = out_c_q;
  assign reg_d_o  = out_d_q;
  assign depth_o  = out_depth_q;

endmodule

`default_nettype wire

// File: sim/four_register_alu_stack_executor_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the four-register ALU stack executor core.
module four_register_alu_stack_executor_core_tb;

  localparam int unsigned StackDepth    = fras_pkg::DefStackDepth;
  localparam int unsigned NumRandom     = 2000;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned TailCycles    = 80;

  typedef struct {
    logic [fras_pkg::OpW-1:0]     op;
    logic [fras_pkg::RegIdxW-1:0] dst;
    logic                         src_is_reg;
    logic [fras_pkg::RegIdxW-1:0] src_reg;
    logic [fras_pkg::DataW-1:0]   imm;
    int unsigned                  phase;
  } instr_word_t;

  typedef struct {
    logic [1:0]                      status;
    logic [3:0][fras_pkg::DataW-1:0] regs;
    logic [fras_pkg::DepthW-1:0]     depth;
  } exec_word_t;

  logic                                clk_i        = 1'b0;
  logic                                rst_ni       = 1'b0;
  logic                                push         = 1'b0;
  logic                                pop          = 1'b0;
  logic [fras_pkg::OpW-1:0]            op_i         = '0;
  logic [fras_pkg::RegIdxW-1:0]        dest_reg_i   = '0;
  logic                                src_is_reg_i = 1'b0;
  logic [fras_pkg::RegIdxW-1:0]        src_reg_i    = '0;
  logic signed [fras_pkg::DataW-1:0]   immediate_i  = '0;
  logic                                full;
  logic                                empty;
  logic [1:0]                          status_o;
  logic signed [fras_pkg::DataW-1:0]   reg_a_o;
  logic signed [fras_pkg::DataW-1:0]   reg_b_o;
  logic signed [fras_pkg::DataW-1:0]   reg_c_o;
  logic signed [fras_pkg::DataW-1:0]   reg_d_o;
  logic [fras_pkg::DepthW-1:0]         depth_o;

  logic [fras_pkg::DataW-1:0] gpr [4] = '{default: '0};
  logic [fras_pkg::DataW-1:0] stack_mem [StackDepth];
  int unsigned                stack_cnt = 0;

  instr_word_t instr_q [$];
  exec_word_t  expected_q [$];
  instr_word_t drv_word;
  exec_word_t  drv_exp;
  exec_word_t  mon_exp;
  int unsigned cur_phase   = 0;
  int unsigned err_cnt     = 0;
  int unsigned idle_cycles = 0;

  int unsigned send_idle_pct  [4] = '{0, 57, 0, 13};
  int unsigned recv_stall_pct [4] = '{0, 0, 57, 13};

  always #2 clk_i = ~clk_i;

  four_register_alu_stack_executor_core #(
    .StackDepth(StackDepth)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .op_i        (op_i),
    .dest_reg_i  (dest_reg_i),
    .src_is_reg_i(src_is_reg_i),
    .src_reg_i   (src_reg_i),
    .immediate_i (immediate_i),
    .empty       (empty),
    .pop         (pop),
    .status_o    (status_o),
    .reg_a_o     (reg_a_o),
    .reg_b_o     (reg_b_o),
    .reg_c_o     (reg_c_o),
    .reg_d_o     (reg_d_o),
    .depth_o     (depth_o)
  );

  function automatic logic [fras_pkg::DataW-1:0] div_trunc(
      input logic [fras_pkg::DataW-1:0] n,
      input logic [fras_pkg::DataW-1:0] d);
    logic [fras_pkg::DataW-1:0] mn;
    logic [fras_pkg::DataW-1:0] md;
    logic [fras_pkg::DataW-1:0] q;
    mn = n[fras_pkg::DataW-1] ? (32'd0 - n) : n;
    md = d[fras_pkg::DataW-1] ? (32'd0 - d) : d;
    q  = mn / md;
    return (n[fras_pkg::DataW-1] != d[fras_pkg::DataW-1]) ? (32'd0 - q) : q;
  endfunction

  task automatic exec_instr(input instr_word_t w, output exec_word_t r);
    logic [fras_pkg::DataW-1:0] src;
    logic [fras_pkg::DataW-1:0] cur;
    r.status = fras_pkg::STAT_OK;
    src = w.src_is_reg ? gpr[w.src_reg] : w.imm;
    cur = gpr[w.dst];
    case (w.op)
      fras_pkg::OP_MOV: gpr[w.dst] = src;
      fras_pkg::OP_ADD: gpr[w.dst] = cur + src;
      fras_pkg::OP_SUB: gpr[w.dst] = cur - src;
      fras_pkg::OP_MUL: gpr[w.dst] = cur * src;
      fras_pkg::OP_DIV: begin
        if (src == '0) r.status = fras_pkg::STAT_DIV0;
        else gpr[w.dst] = div_trunc(cur, src);
      end
      fras_pkg::OP_XOR: gpr[w.dst] = cur ^ src;
      fras_pkg::OP_AND: gpr[w.dst] = cur & src;
      fras_pkg::OP_OR:  gpr[w.dst] = cur | src;
      fras_pkg::OP_SHL: gpr[w.dst] = cur << src[4:0];
      fras_pkg::OP_SHR: gpr[w.dst] = $signed(cur) >>> src[4:0];
      fras_pkg::OP_PUSH: begin
        if (stack_cnt >= StackDepth) begin
          r.status = fras_pkg::STAT_OVER;
        end else begin
          stack_mem[stack_cnt] = src;
          stack_cnt++;
        end
      end
      fras_pkg::OP_POP: begin
        if (stack_cnt == 0) begin
          r.status = fras_pkg::STAT_UNDER;
        end else begin
          stack_cnt--;
          gpr[w.dst] = stack_mem[stack_cnt];
        end
      end
      default: ;
    endcase
    r.regs  = {gpr[3], gpr[2], gpr[1], gpr[0]};
    r.depth = fras_pkg::DepthW'(stack_cnt);
  endtask

  task automatic check_field(input string name, input logic [fras_pkg::DataW-1:0] exp_v,
                             input logic [fras_pkg::DataW-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  function automatic instr_word_t mk_instr(input logic [fras_pkg::OpW-1:0] op,
                                           input logic [fras_pkg::RegIdxW-1:0] dst,
                                           input logic is_reg,
                                           input logic [fras_pkg::RegIdxW-1:0] sreg,
                                           input logic [fras_pkg::DataW-1:0] imm);
    instr_word_t w;
    w.op         = op;
    w.dst        = dst;
    w.src_is_reg = is_reg;
    w.src_reg    = sreg;
    w.imm        = imm;
    w.phase      = 0;
    return w;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (!push || !full) begin
      if (push) begin
        exec_instr(drv_word, drv_exp);
        expected_q.push_back(drv_exp);
      end
      if (instr_q.size() > 0 && $urandom_range(99) >= send_idle_pct[instr_q[0].phase]) begin
        drv_word = instr_q.pop_front();
        push         <= 1'b1;
        op_i         <= drv_word.op;
        dest_reg_i   <= drv_word.dst;
        src_is_reg_i <= drv_word.src_is_reg;
        src_reg_i    <= drv_word.src_reg;
        immediate_i  <= drv_word.imm;
        cur_phase    <= drv_word.phase;
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          $error("result word with no instruction pending: status %0d", status_o);
          err_cnt++;
        end else begin
          mon_exp = expected_q.pop_front();
          check_field("status", fras_pkg::DataW'(mon_exp.status), fras_pkg::DataW'(status_o));
          check_field("reg_a", mon_exp.regs[0], reg_a_o);
          check_field("reg_b", mon_exp.regs[1], reg_b_o);
          check_field("reg_c", mon_exp.regs[2], reg_c_o);
          check_field("reg_d", mon_exp.regs[3], reg_d_o);
          check_field("depth", fras_pkg::DataW'(mon_exp.depth), fras_pkg::DataW'(depth_o));
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct[cur_phase]);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("four_register_alu_stack_executor_core_tb: done, errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    instr_word_t w;
    int unsigned mode;
    int unsigned k;
    mode = 0;
    rst_ni = 1'b0;

    // Extremes, wrap-around, the divide corner cases, shifts and the empty-stack edge.
    instr_q.push_back(mk_instr(fras_pkg::OP_MOV, 2'd0, 1'b0, 2'd0, 32'h7fff_ffff));
    instr_q.push_back(mk_instr(fras_pkg::OP_MOV, 2'd1, 1'b0, 2'd3, 32'h8000_0000));
    instr_q.push_back(mk_instr(fras_pkg::OP_MOV, 2'd2, 1'b0, 2'd0, 32'hffff_ffff));
    instr_q.push_back(mk_instr(fras_pkg::OP_ADD, 2'd0, 1'b0, 2'd0, 32'd1));
    instr_q.push_back(mk_instr(fras_pkg::OP_SUB, 2'd1, 1'b0, 2'd0, 32'd1));
    instr_q.push_back(mk_instr(fras_pkg::OP_MUL, 2'd2, 1'b1, 2'd2, 32'd0));
    instr_q.push_back(mk_instr(fras_pkg::OP_MOV, 2'd3, 1'b0, 2'd0, 32'h8000_0000));
    instr_q.push_back(mk_instr(fras_pkg::OP_DIV, 2'd3, 1'b0, 2'd0, 32'hffff_ffff));
    instr_q.push_back(mk_instr(fras_pkg::OP_DIV, 2'd0, 1'b0, 2'd0, 32'd0));
    instr_q.push_back(mk_instr(fras_pkg::OP_DIV, 2'd1, 1'b0, 2'd0, 32'hffff_fff9));
    instr_q.push_back(mk_instr(fras_pkg::OP_XOR, 2'd2, 1'b0, 2'd0, 32'ha5a5_a5a5));
    instr_q.push_back(mk_instr(fras_pkg::OP_AND, 2'd2, 1'b1, 2'd1, 32'd0));
    instr_q.push_back(mk_instr(fras_pkg::OP_OR,  2'd2, 1'b0, 2'd0, 32'h0f0f_0000));
    instr_q.push_back(mk_instr(fras_pkg::OP_SHL, 2'd1, 1'b0, 2'd0, 32'd33));
    instr_q.push_back(mk_instr(fras_pkg::OP_SHR, 2'd3, 1'b0, 2'd0, 32'd31));
    instr_q.push_back(mk_instr(fras_pkg::OP_SHR, 2'd0, 1'b0, 2'd0, 32'hffff_ffe0));
    instr_q.push_back(mk_instr(fras_pkg::OP_POP, 2'd0, 1'b0, 2'd0, 32'd0));
    instr_q.push_back(mk_instr(fras_pkg::OP_PUSH, 2'd0, 1'b0, 2'd0, 32'h8000_0000));
    instr_q.push_back(mk_instr(fras_pkg::OP_PUSH, 2'd0, 1'b1, 2'd3, 32'd0));
    instr_q.push_back(mk_instr(fras_pkg::OP_POP, 2'd2, 1'b0, 2'd0, 32'd0));
    instr_q.push_back(mk_instr(fras_pkg::OP_POP, 2'd1, 1'b0, 2'd0, 32'd0));
    instr_q.push_back(mk_instr(4'd12, 2'd0, 1'b0, 2'd0, 32'd5));
    instr_q.push_back(mk_instr(4'd15, 2'd3, 1'b1, 2'd3, 32'hffff_ffff));
    instr_q.push_back(mk_instr(fras_pkg::OP_MOV, 2'd0, 1'b0, 2'd0, 32'hffff_fff7));
    instr_q.push_back(mk_instr(fras_pkg::OP_DIV, 2'd0, 1'b0, 2'd0, 32'd2));

    // Runs of push-heavy and pop-heavy traffic drive the stack to both ends.
    for (int unsigned n = 0; n < NumRandom; n++) begin
      if (n % 40 == 0) mode = $urandom_range(2);
      w.phase = (n * 4) / NumRandom;
      k = $urandom_range(99);
      if (mode == 1 && k < 65) w.op = fras_pkg::OP_PUSH;
      else if (mode == 2 && k < 55) w.op = fras_pkg::OP_POP;
      else w.op = fras_pkg::OpW'($urandom_range(15));
      w.dst        = fras_pkg::RegIdxW'($urandom_range(3));
      w.src_is_reg = 1'($urandom_range(1));
      w.src_reg    = fras_pkg::RegIdxW'($urandom_range(3));
      case ($urandom_range(7))
        0: w.imm = 32'h8000_0000;
        1: w.imm = 32'h7fff_ffff;
        2: w.imm = 32'hffff_ffff;
        3: w.imm = 32'd0;
        4: w.imm = $urandom_range(40);
        default: w.imm = $urandom;
      endcase
      instr_q.push_back(w);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (instr_q.size() > 0 || push) @(posedge clk_i);
    while (expected_q.size() > 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("four_register_alu_stack_executor_core_tb: done, clean");
    end else begin
      $display("four_register_alu_stack_executor_core_tb: done, errors");
    end
    $finish;
  end

endmodule
